@@ src/wsp_pkg.sv @@
// package: shared types and constants for the weighted-sum pooling core
`timescale 1ns / 1ps
package wsp_pkg;

  localparam int MAX_KERNEL     = 8;
  localparam int MAX_PLANE_COLS = 1024;
  localparam int MAX_PLANE_ROWS = 1024;

  localparam int KR_W   = $clog2(MAX_KERNEL);
  localparam int COL_W  = $clog2(MAX_PLANE_COLS);
  localparam int ROW_W  = $clog2(MAX_PLANE_ROWS);
  localparam int ADDR_W = KR_W + COL_W;
  // row partial sum: up to MAX_KERNEL samples of 16 bits
  localparam int RSUM_W = 16 + $clog2(MAX_KERNEL) + 1;
  // window sum: up to MAX_KERNEL row sums
  localparam int WSUM_W = RSUM_W + $clog2(MAX_KERNEL) + 1;
  localparam int PROD_W = WSUM_W + 16;

  // register indexes
  localparam logic [2:0] REG_KROWS = 3'd0;
  localparam logic [2:0] REG_KCOLS = 3'd1;
  localparam logic [2:0] REG_SROWS = 3'd2;
  localparam logic [2:0] REG_SCOLS = 3'd3;
  localparam logic [2:0] REG_PROWS = 3'd4;
  localparam logic [2:0] REG_PCOLS = 3'd5;

  typedef struct packed {
    logic signed [15:0] sample;
    logic signed [15:0] plane_weight;
    logic signed [23:0] plane_bias;
  } in_beat_t;

  typedef struct packed {
    logic signed [25:0] pooled_value;
    logic [9:0]         out_row;
    logic [9:0]         out_col;
    logic               last_of_plane;
  } out_beat_t;

  // control passed from the sequencer into the cell chain
  typedef struct packed {
    logic                     load;   // start a new window: clear the chain
    logic                     shift;  // a row sum enters the chain
    logic signed [RSUM_W-1:0] rsum;
  } chain_ctl_t;

endpackage

@@ src/wsp_cell.sv @@
// one accumulating cell of the row-sum chain
`timescale 1ns / 1ps
module wsp_cell (
  input  logic                              clk,
  input  wsp_pkg::chain_ctl_t               ctl,
  input  logic signed [wsp_pkg::WSUM_W-1:0] acc_in,
  output logic signed [wsp_pkg::WSUM_W-1:0] acc_out
);

  logic signed [wsp_pkg::WSUM_W-1:0] acc_r;
  logic signed [wsp_pkg::WSUM_W-1:0] acc_nxt;

  // each cell adds one row sum to what its neighbor hands over
  always_comb begin
    acc_nxt = acc_r;
    if (ctl.load) begin
      acc_nxt = '0;
    end else if (ctl.shift) begin
      acc_nxt = acc_in + wsp_pkg::WSUM_W'(ctl.rsum);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc_out = acc_r;

endmodule

@@ src/wsp_chain.sv @@
// row of cells that folds row sums into the window sum
`timescale 1ns / 1ps
module wsp_chain (
  input  logic                              clk,
  input  wsp_pkg::chain_ctl_t               ctl,
  input  logic [wsp_pkg::KR_W:0]            taps,
  output logic signed [wsp_pkg::WSUM_W-1:0] wsum
);

  logic signed [wsp_pkg::WSUM_W-1:0] link [wsp_pkg::MAX_KERNEL+1];

  assign link[0] = '0;

  for (genvar g = 0; g < wsp_pkg::MAX_KERNEL; g++) begin : g_cell
    wsp_cell u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .acc_in (link[g]),
      .acc_out(link[g+1])
    );
  end

  // the cell at the kernel height has seen every row sum of the window
  always_comb begin
    wsum = '0;
    for (int i = 1; i <= wsp_pkg::MAX_KERNEL; i++) begin
      if (taps == (wsp_pkg::KR_W+1)'(i)) begin
        wsum = link[i];
      end
    end
  end

endmodule

@@ src/weighted_sum_pooling_forward_core.sv @@
// top level: control, line store, row summing and output stage
// a pixel that closes no window leaves the core idle and ready for the next
// pixel; after one that closes a window the next pixel waits until the walk,
// multiply, add and output states are done and the result beat is taken; the
// walk is set by the single line-store read port feeding the cell chain one
// sample per cycle within a row. Only one window is worked on at a time.
// reset: synchronous active-low rst_n restores default registers and
// positions; the line store has no reset and is always written before read.
`timescale 1ns / 1ps
module weighted_sum_pooling_forward_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  wsp_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output wsp_pkg::out_beat_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int KR_W   = wsp_pkg::KR_W;
  localparam int COL_W  = wsp_pkg::COL_W;
  localparam int ROW_W  = wsp_pkg::ROW_W;
  localparam int RSUM_W = wsp_pkg::RSUM_W;
  localparam int WSUM_W = wsp_pkg::WSUM_W;
  localparam int PROD_W = wsp_pkg::PROD_W;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_READ = 6'b000010,
    ST_ROW  = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_ADD  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  // configuration registers
  logic [3:0]  krows_r, kcols_r, srows_r, scols_r;
  logic [10:0] prows_r, pcols_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (cfg_idx)
      wsp_pkg::REG_KROWS: cfg_prdata = {28'd0, krows_r};
      wsp_pkg::REG_KCOLS: cfg_prdata = {28'd0, kcols_r};
      wsp_pkg::REG_SROWS: cfg_prdata = {28'd0, srows_r};
      wsp_pkg::REG_SCOLS: cfg_prdata = {28'd0, scols_r};
      wsp_pkg::REG_PROWS: cfg_prdata = {21'd0, prows_r};
      wsp_pkg::REG_PCOLS: cfg_prdata = {21'd0, pcols_r};
      default:            cfg_prdata = '0;
    endcase
  end

  // effective (clamped) geometry
  logic [KR_W:0]  kr, kc;
  logic [3:0]     sr, sc;
  logic [ROW_W:0] pr;
  logic [COL_W:0] pc;

  always_comb begin
    kr = (krows_r == 4'd0) ? (KR_W+1)'(1) :
         (krows_r > 4'(wsp_pkg::MAX_KERNEL)) ? (KR_W+1)'(wsp_pkg::MAX_KERNEL) :
         (KR_W+1)'(krows_r);
    kc = (kcols_r == 4'd0) ? (KR_W+1)'(1) :
         (kcols_r > 4'(wsp_pkg::MAX_KERNEL)) ? (KR_W+1)'(wsp_pkg::MAX_KERNEL) :
         (KR_W+1)'(kcols_r);
    sr = (srows_r == 4'd0) ? 4'd1 : srows_r;
    sc = (scols_r == 4'd0) ? 4'd1 : scols_r;
    pr = (prows_r == 11'd0) ? (ROW_W+1)'(1) :
         (prows_r > 11'(wsp_pkg::MAX_PLANE_ROWS)) ? (ROW_W+1)'(wsp_pkg::MAX_PLANE_ROWS) :
         (ROW_W+1)'(prows_r);
    pc = (pcols_r == 11'd0) ? (COL_W+1)'(1) :
         (pcols_r > 11'(wsp_pkg::MAX_PLANE_COLS)) ? (COL_W+1)'(wsp_pkg::MAX_PLANE_COLS) :
         (COL_W+1)'(pcols_r);
  end

  // position and stride-phase counters
  state_t          state_r, state_nxt;
  logic [ROW_W:0]  row_r;
  logic [COL_W:0]  col_r;
  logic [3:0]      rph_r, cph_r;     // (origin - 0) modulo stride, tracked
  logic [ROW_W-1:0] orow_r;
  logic [COL_W-1:0] ocol_r;
  logic            accept;
  logic            row_ok, col_ok, rgrid, cgrid, fire;
  logic [ROW_W:0]  r0;
  logic [COL_W:0]  c0;

  assign in_ready = (state_r == ST_IDLE) && !out_valid;
  assign accept   = in_valid && in_ready;

  // window origin of the current pixel
  assign r0     = row_r + (ROW_W+1)'(1) - (ROW_W+1)'(kr);
  assign c0     = col_r + (COL_W+1)'(1) - (COL_W+1)'(kc);
  assign row_ok = (row_r + (ROW_W+1)'(1)) >= (ROW_W+1)'(kr);
  assign col_ok = (col_r + (COL_W+1)'(1)) >= (COL_W+1)'(kc);
  assign rgrid  = (rph_r == 4'd0);
  assign cgrid  = (cph_r == 4'd0);
  assign fire   = row_ok && col_ok && rgrid && cgrid;

  // rph/cph count origin position modulo stride once the origin is >= 0
  logic [3:0]       rph_nxt, cph_nxt;
  logic [ROW_W-1:0] orow_nxt;
  logic [COL_W-1:0] ocol_nxt;
  logic [ROW_W:0]   row_nxt;
  logic [COL_W:0]   col_nxt;
  logic             col_wrap;

  always_comb begin
    col_wrap = (col_r + (COL_W+1)'(1)) >= pc;
    col_nxt  = col_r + (COL_W+1)'(1);
    row_nxt  = row_r;
    cph_nxt  = cph_r;
    ocol_nxt = ocol_r;
    rph_nxt  = rph_r;
    orow_nxt = orow_r;
    if (col_ok) begin
      if (cph_r + 4'd1 >= sc) begin
        cph_nxt  = 4'd0;
        ocol_nxt = ocol_r + COL_W'(1);
      end else begin
        cph_nxt = cph_r + 4'd1;
      end
    end
    if (col_wrap) begin
      col_nxt  = '0;
      cph_nxt  = '0;
      ocol_nxt = '0;
      row_nxt  = row_r + (ROW_W+1)'(1);
      if (row_ok) begin
        if (rph_r + 4'd1 >= sr) begin
          rph_nxt  = 4'd0;
          orow_nxt = orow_r + ROW_W'(1);
        end else begin
          rph_nxt = rph_r + 4'd1;
        end
      end
      if (row_r + (ROW_W+1)'(1) >= pr) begin
        row_nxt  = '0;
        rph_nxt  = '0;
        orow_nxt = '0;
      end
    end
  end

  // line store: one write port, one registered read port
  logic signed [15:0] store_mem [wsp_pkg::MAX_KERNEL*wsp_pkg::MAX_PLANE_COLS];
  logic [wsp_pkg::ADDR_W-1:0] wr_addr, rd_addr;
  logic signed [15:0] rd_data_r;

  assign wr_addr = {row_r[KR_W-1:0], col_r[COL_W-1:0]};

  // window walk counters
  logic [KR_W:0]  wr_row_r, wr_col_r;     // read issue position
  logic           rd_vld_r;               // read data in rd_data_r is valid
  logic           rd_last_col_r;          // read data closes a row
  logic [KR_W:0]  rows_done_r;
  logic signed [RSUM_W-1:0] rsum_r;
  logic signed [15:0] weight_r;
  logic signed [23:0] bias_r;
  logic [ROW_W:0] wr0_r;
  logic [COL_W:0] wc0_r;
  logic           last_r;
  logic [ROW_W:0] lrow;
  logic [COL_W:0] lcol;
  logic [ROW_W:0] rd_row;

  assign rd_row  = wr0_r + (ROW_W+1)'(wr_row_r);
  assign rd_addr = {rd_row[KR_W-1:0], COL_W'(wc0_r + (COL_W+1)'(wr_col_r))};

  always_ff @(posedge clk) begin
    if (accept) begin
      store_mem[wr_addr] <= in_data.sample;
    end
    rd_data_r <= store_mem[rd_addr];
  end

  // last-window position, compared against stride-grid counters
  always_comb begin
    lrow = pr - (ROW_W+1)'(kr);
    lcol = pc - (COL_W+1)'(kc);
  end

  // cell chain control
  wsp_pkg::chain_ctl_t ctl;
  logic signed [WSUM_W-1:0] wsum;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] val;
  logic signed [25:0] res_r;
  wsp_pkg::out_beat_t out_r;
  logic out_valid_r;
  logic issuing;

  assign issuing = (state_r == ST_READ);

  always_comb begin
    ctl.load  = accept;
    ctl.shift = (state_r == ST_ROW);
    ctl.rsum  = rsum_r;
  end

  wsp_chain u_chain (
    .clk (clk),
    .ctl (ctl),
    .taps(kr),
    .wsum(wsum)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept && fire) state_nxt = ST_READ;
      ST_READ: if (rd_vld_r && rd_last_col_r) state_nxt = ST_ROW;
      ST_ROW:  state_nxt = (rows_done_r + (KR_W+1)'(1) >= kr) ? ST_MUL : ST_READ;
      ST_MUL:  state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_OUT;
      ST_OUT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // product shifted right 12 arithmetically, then bias, with saturation
  always_comb begin
    val = (prod_r >>> 12) + PROD_W'(bias_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      krows_r <= 4'd2;
      kcols_r <= 4'd2;
      srows_r <= 4'd2;
      scols_r <= 4'd2;
      prows_r <= 11'd32;
      pcols_r <= 11'd32;
      row_r   <= '0;
      col_r   <= '0;
      rph_r   <= '0;
      cph_r   <= '0;
      orow_r  <= '0;
      ocol_r  <= '0;
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && cfg_idx <= wsp_pkg::REG_PCOLS) begin
        case (cfg_idx)
          wsp_pkg::REG_KROWS: krows_r <= cfg_pwdata[3:0];
          wsp_pkg::REG_KCOLS: kcols_r <= cfg_pwdata[3:0];
          wsp_pkg::REG_SROWS: srows_r <= cfg_pwdata[3:0];
          wsp_pkg::REG_SCOLS: scols_r <= cfg_pwdata[3:0];
          wsp_pkg::REG_PROWS: prows_r <= cfg_pwdata[10:0];
          wsp_pkg::REG_PCOLS: pcols_r <= cfg_pwdata[10:0];
          default: ;
        endcase
        row_r  <= '0;
        col_r  <= '0;
        rph_r  <= '0;
        cph_r  <= '0;
        orow_r <= '0;
        ocol_r <= '0;
      end else if (accept) begin
        row_r  <= row_nxt;
        col_r  <= col_nxt;
        rph_r  <= rph_nxt;
        cph_r  <= cph_nxt;
        orow_r <= orow_nxt;
        ocol_r <= ocol_nxt;
      end
      rd_vld_r <= issuing && !(rd_vld_r && rd_last_col_r) && (wr_col_r < kc);
      if (state_r == ST_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers for the window walk
  always_ff @(posedge clk) begin
    if (accept) begin
      weight_r    <= in_data.plane_weight;
      bias_r      <= in_data.plane_bias;
      wr0_r       <= r0;
      wc0_r       <= c0;
      wr_row_r    <= '0;
      wr_col_r    <= '0;
      rows_done_r <= '0;
      rsum_r      <= '0;
      out_r.out_row <= 10'(orow_r);
      out_r.out_col <= 10'(ocol_r);
      last_r      <= (r0 == (ROW_W+1)'(orow_r) * (ROW_W+1)'(sr)) &&
                     ((ROW_W+1)'(orow_r) * (ROW_W+1)'(sr) + (ROW_W+1)'(sr) > lrow) &&
                     ((COL_W+1)'(ocol_r) * (COL_W+1)'(sc) + (COL_W+1)'(sc) > lcol);
    end
    // issue one read per cycle across the current row
    if (issuing && wr_col_r < kc) begin
      wr_col_r <= wr_col_r + (KR_W+1)'(1);
    end
    rd_last_col_r <= issuing && (wr_col_r + (KR_W+1)'(1) == kc);
    if (rd_vld_r) begin
      rsum_r <= rsum_r + RSUM_W'(rd_data_r);
    end
    if (state_r == ST_ROW) begin
      rows_done_r <= rows_done_r + (KR_W+1)'(1);
      wr_row_r    <= wr_row_r + (KR_W+1)'(1);
      wr_col_r    <= '0;
      rsum_r      <= '0;
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_W'(wsum) * PROD_W'(weight_r);
    end
    if (state_r == ST_ADD) begin
      if (val > PROD_W'(33554431)) begin
        res_r <= 26'sh1FFFFFF;
      end else if (val < -PROD_W'(33554432)) begin
        res_r <= -26'sd33554432;
      end else begin
        res_r <= 26'(val);
      end
    end
    if (state_r == ST_OUT) begin
      out_r.pooled_value  <= res_r;
      out_r.last_of_plane <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
